### hdl/tmb_pkg.sv
package tmb_pkg;

  localparam int GridCells = 81;
  localparam int CellIdxW = 7;
  localparam logic [8:0] CellLast = 9'd80;
  localparam logic [8:0] RowStride = 9'd9;

  localparam logic [11:0] FullScale = 12'h800;
  localparam logic [11:0] PivotMid = 12'h400;
  localparam logic [7:0] ByteMax = 8'hff;
  localparam logic [7:0] SpeedStop = 8'd128;
  localparam logic [7:0] GridCol = 8'd9;
  localparam logic [7:0] ColLast = 8'd8;

  // offset / 24 = (offset / 8) / 3, and k / 3 = (k * 171) >> 9 for k <= 128
  localparam logic [16:0] RecipThird = 17'd171;
  localparam int RecipShift = 9;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegPulseBase = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPulseStep = 2'd1;
  localparam logic [15:0] PulseBaseReset = 16'd18204;
  localparam logic [7:0] PulseStepReset = 8'd40;

  localparam logic [7:0] RightGrid [GridCells] = '{
    8'd128, 8'd96,  8'd64,  8'd32,  8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd128, 8'd104, 8'd80,  8'd56,  8'd32,  8'd32,  8'd32,  8'd32,  8'd32,
    8'd128, 8'd112, 8'd96,  8'd80,  8'd64,  8'd64,  8'd64,  8'd64,  8'd64,
    8'd128, 8'd120, 8'd112, 8'd104, 8'd96,  8'd96,  8'd96,  8'd96,  8'd96,
    8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128,
    8'd128, 8'd136, 8'd144, 8'd152, 8'd160, 8'd160, 8'd160, 8'd160, 8'd160,
    8'd128, 8'd144, 8'd160, 8'd176, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd128, 8'd152, 8'd176, 8'd200, 8'd224, 8'd224, 8'd224, 8'd224, 8'd224,
    8'd128, 8'd160, 8'd192, 8'd224, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  localparam logic [7:0] LeftGrid [GridCells] = '{
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd32,  8'd64,  8'd96,  8'd128,
    8'd32,  8'd32,  8'd32,  8'd32,  8'd32,  8'd56,  8'd80,  8'd104, 8'd128,
    8'd64,  8'd64,  8'd64,  8'd64,  8'd64,  8'd80,  8'd96,  8'd112, 8'd128,
    8'd96,  8'd96,  8'd96,  8'd96,  8'd96,  8'd104, 8'd112, 8'd120, 8'd128,
    8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128,
    8'd160, 8'd160, 8'd160, 8'd160, 8'd160, 8'd152, 8'd144, 8'd136, 8'd128,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd176, 8'd160, 8'd144, 8'd128,
    8'd224, 8'd224, 8'd224, 8'd224, 8'd224, 8'd200, 8'd176, 8'd152, 8'd128,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd224, 8'd192, 8'd160, 8'd128
  };

  typedef struct packed {
    logic [3:0][7:0] lc;
    logic [3:0][7:0] rc;
    logic [7:0] fy;
    logic [7:0] fx;
    logic pivot;
    logic [7:0] pivot_left;
  } cells_t;

  typedef struct packed {
    logic [15:0] le02;
    logic [15:0] le13;
    logic [15:0] re02;
    logic [15:0] re13;
    logic [7:0] fx;
    logic pivot;
    logic [7:0] pivot_left;
  } edges_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic pivot;
  } speed_t;

  function automatic logic [11:0] scale_byte(input logic [7:0] b);
    logic [11:0] v;
    if (b == ByteMax) begin
      v = FullScale;
    end else begin
      v = {1'b0, b, 3'd0};
    end
    return v;
  endfunction

  function automatic logic [CellIdxW-1:0] clamp_idx(input logic [8:0] i);
    logic [8:0] c;
    c = (i > CellLast) ? CellLast : i;
    return c[CellIdxW-1:0];
  endfunction

  function automatic logic [15:0] lerp_edge(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] f);
    logic [15:0] r;
    if (b > a) begin
      r = ({8'd0, b - a} * {8'd0, f}) + {a, 8'd0};
    end else begin
      r = {a, 8'd0} - ({8'd0, a - b} * {8'd0, f});
    end
    return r;
  endfunction

endpackage

### hdl/tmb_if.sv
interface tmb_cmd_if;
  logic valid;
  logic ready;
  logic [7:0] throttle;
  logic [7:0] steer;
  modport source(output valid, output throttle, output steer, input ready);
  modport sink(input valid, input throttle, input steer, output ready);
endinterface

interface tmb_res_if;
  logic valid;
  logic ready;
  logic [7:0] left_speed;
  logic [7:0] right_speed;
  logic [15:0] left_reload;
  logic [15:0] right_reload;
  logic pivot_turn;
  modport source(output valid, output left_speed, output right_speed, output left_reload,
                 output right_reload, output pivot_turn, input ready);
  modport sink(input valid, input left_speed, input right_speed, input left_reload,
               input right_reload, input pivot_turn, output ready);
endinterface

interface tmb_cfg_if;
  logic valid;
  logic ready;
  logic [tmb_pkg::CfgIdxW-1:0] index;
  logic [tmb_pkg::CfgDataW-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

### hdl/tmb_index.sv
module tmb_index (
  input  logic            clk,
  input  logic            rst,
  tmb_cmd_if.sink         cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output tmb_pkg::cells_t out
);

  logic [11:0] y;
  logic [11:0] x;
  logic [7:0] w0;
  logic [7:0] w1;
  logic [8:0] i2;
  logic [8:0] i3;
  logic [tmb_pkg::CellIdxW-1:0] a0;
  logic [tmb_pkg::CellIdxW-1:0] a1;
  logic [tmb_pkg::CellIdxW-1:0] a2;
  logic [tmb_pkg::CellIdxW-1:0] a3;
  logic [11:0] offset;
  logic [16:0] third;
  logic [7:0] q;
  tmb_pkg::cells_t next;

  assign y = tmb_pkg::scale_byte(cmd.throttle);
  assign x = tmb_pkg::scale_byte(cmd.steer);
  assign w0 = {4'd0, y[11:8]} * tmb_pkg::GridCol + tmb_pkg::ColLast - {4'd0, x[11:8]};
  assign w1 = (x < tmb_pkg::FullScale) ? w0 - 8'd1 : w0;
  assign i2 = (y < tmb_pkg::FullScale) ? {1'b0, w1} + tmb_pkg::RowStride : {1'b0, w1};
  assign i3 = (y < tmb_pkg::FullScale) ? {1'b0, w0} + tmb_pkg::RowStride : {1'b0, w0};
  assign a0 = tmb_pkg::clamp_idx({1'b0, w1});
  assign a1 = tmb_pkg::clamp_idx({1'b0, w0});
  assign a2 = tmb_pkg::clamp_idx(i2);
  assign a3 = tmb_pkg::clamp_idx(i3);

  assign offset = (x > tmb_pkg::PivotMid) ? x - tmb_pkg::PivotMid : tmb_pkg::PivotMid - x;
  assign third = {9'd0, offset[10:3]} * tmb_pkg::RecipThird;
  assign q = third[tmb_pkg::RecipShift +: 8];

  always_comb begin
    next.lc[0] = tmb_pkg::LeftGrid[a0];
    next.lc[1] = tmb_pkg::LeftGrid[a1];
    next.lc[2] = tmb_pkg::LeftGrid[a2];
    next.lc[3] = tmb_pkg::LeftGrid[a3];
    next.rc[0] = tmb_pkg::RightGrid[a0];
    next.rc[1] = tmb_pkg::RightGrid[a1];
    next.rc[2] = tmb_pkg::RightGrid[a2];
    next.rc[3] = tmb_pkg::RightGrid[a3];
    next.fy = y[7:0];
    next.fx = x[7:0];
    next.pivot = (y == tmb_pkg::PivotMid);
    next.pivot_left = (x > tmb_pkg::PivotMid) ? tmb_pkg::SpeedStop + q : tmb_pkg::SpeedStop - q;
  end

  assign cmd.ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ready) begin
      out_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      out <= next;
    end
  end

endmodule

### hdl/tmb_edge.sv
module tmb_edge (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmb_pkg::cells_t in,
  output logic            out_valid,
  input  logic            out_ready,
  output tmb_pkg::edges_t out
);

  tmb_pkg::edges_t next;

  always_comb begin
    next.le02 = tmb_pkg::lerp_edge(in.lc[0], in.lc[2], in.fy);
    next.le13 = tmb_pkg::lerp_edge(in.lc[1], in.lc[3], in.fy);
    next.re02 = tmb_pkg::lerp_edge(in.rc[0], in.rc[2], in.fy);
    next.re13 = tmb_pkg::lerp_edge(in.rc[1], in.rc[3], in.fy);
    next.fx = in.fx;
    next.pivot = in.pivot;
    next.pivot_left = in.pivot_left;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= next;
    end
  end

endmodule

### hdl/tmb_blend.sv
module tmb_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmb_pkg::edges_t in,
  output logic            out_valid,
  input  logic            out_ready,
  output tmb_pkg::speed_t out
);

  function automatic logic [7:0] blend(input logic [15:0] e02, input logic [15:0] e13,
                                       input logic [7:0] fx);
    logic lt;
    logic [15:0] diff;
    logic [15:0] hi;
    logic [15:0] lop;
    logic [15:0] lo;
    logic [15:0] ans;
    lt = e13 < e02;
    diff = lt ? e02 - e13 : e13 - e02;
    hi = {8'd0, fx} * {8'd0, diff[15:8]};
    lop = {8'd0, fx} * {8'd0, diff[7:0]};
    lo = {8'd0, lop[15:8]};
    ans = lt ? e13 + hi + lo : e13 - hi - lo;
    return ans[7] ? ans[15:8] + 8'd1 : ans[15:8];
  endfunction

  tmb_pkg::speed_t next;

  always_comb begin
    next.pivot = in.pivot;
    if (in.pivot) begin
      next.left = in.pivot_left;
      next.right = 8'd0 - in.pivot_left;
    end else begin
      next.left = blend(in.le02, in.le13, in.fx);
      next.right = blend(in.re02, in.re13, in.fx);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out <= next;
    end
  end

  a_pivot_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.pivot |-> out.left >= 8'd86 && out.left <= 8'd170)
    else $error("pivot speed out of span");

endmodule

### hdl/tmb_reload.sv
module tmb_reload (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmb_pkg::speed_t in,
  tmb_cfg_if.sink         cfg,
  tmb_res_if.source       res
);

  logic [15:0] pulse_base;
  logic [7:0] pulse_step;
  logic [15:0] left_prod;
  logic [15:0] right_prod;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_base <= tmb_pkg::PulseBaseReset;
      pulse_step <= tmb_pkg::PulseStepReset;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tmb_pkg::RegPulseBase: pulse_base <= cfg.data[15:0];
        tmb_pkg::RegPulseStep: pulse_step <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign left_prod = {8'd0, pulse_step} * {8'd0, in.left};
  assign right_prod = {8'd0, pulse_step} * {8'd0, in.right};

  assign in_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_ready) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res.left_speed <= in.left;
      res.right_speed <= in.right;
      res.left_reload <= pulse_base - left_prod;
      res.right_reload <= pulse_base - right_prod;
      res.pivot_turn <= in.pivot;
    end
  end

  a_pivot_mirror: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.pivot_turn |-> res.right_speed == 8'd0 - res.left_speed)
    else $error("pivot right speed does not mirror left");

  a_base_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && cfg.index == tmb_pkg::RegPulseBase
    |=> pulse_base == $past(cfg.data[15:0]))
    else $error("pulse base write lost");

  a_reset_regs: assert property (@(posedge clk)
    rst |=> pulse_base == tmb_pkg::PulseBaseReset && pulse_step == tmb_pkg::PulseStepReset)
    else $error("registers not at reset value");

endmodule

### hdl/track_mixer_bilinear_table_core.sv
// Throughput: one item per cycle; each stage holds while the one after it is full.
// Stages: cell lookup, edge blends, cross blend and round, reload multiply.
// Reset: synchronous, clears all stage valid bits, pulse_base to 18204, pulse_step to 40.
module track_mixer_bilinear_table_core (
  input  logic      clk,
  input  logic      rst,
  tmb_cmd_if.sink   cmd,
  tmb_cfg_if.sink   cfg,
  tmb_res_if.source res
);

  logic cells_valid;
  logic cells_ready;
  tmb_pkg::cells_t cells;
  logic edges_valid;
  logic edges_ready;
  tmb_pkg::edges_t edges;
  logic speed_valid;
  logic speed_ready;
  tmb_pkg::speed_t speed;

  tmb_index u_index (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .out_valid (cells_valid),
    .out_ready (cells_ready),
    .out       (cells)
  );

  tmb_edge u_edge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cells_valid),
    .in_ready  (cells_ready),
    .in        (cells),
    .out_valid (edges_valid),
    .out_ready (edges_ready),
    .out       (edges)
  );

  tmb_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edges_valid),
    .in_ready  (edges_ready),
    .in        (edges),
    .out_valid (speed_valid),
    .out_ready (speed_ready),
    .out       (speed)
  );

  tmb_reload u_reload (
    .clk      (clk),
    .rst      (rst),
    .in_valid (speed_valid),
    .in_ready (speed_ready),
    .in       (speed),
    .cfg      (cfg),
    .res      (res)
  );

endmodule

### verif/track_mixer_bilinear_table_core_tb.sv
module track_mixer_bilinear_table_core_tb;

  localparam int StallLimit = 2000;
  localparam int RandomItems = 1150;
  localparam int RandomPhases = 5;
  localparam logic [tmb_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [tmb_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

  localparam int unsigned RightTrack [81] = '{
    128, 96,  64,  32,  1,   1,   1,   1,   1,
    128, 104, 80,  56,  32,  32,  32,  32,  32,
    128, 112, 96,  80,  64,  64,  64,  64,  64,
    128, 120, 112, 104, 96,  96,  96,  96,  96,
    128, 128, 128, 128, 128, 128, 128, 128, 128,
    128, 136, 144, 152, 160, 160, 160, 160, 160,
    128, 144, 160, 176, 192, 192, 192, 192, 192,
    128, 152, 176, 200, 224, 224, 224, 224, 224,
    128, 160, 192, 224, 255, 255, 255, 255, 255
  };

  localparam int unsigned LeftTrack [81] = '{
    1,   1,   1,   1,   1,   32,  64,  96,  128,
    32,  32,  32,  32,  32,  56,  80,  104, 128,
    64,  64,  64,  64,  64,  80,  96,  112, 128,
    96,  96,  96,  96,  96,  104, 112, 120, 128,
    128, 128, 128, 128, 128, 128, 128, 128, 128,
    160, 160, 160, 160, 160, 152, 144, 136, 128,
    192, 192, 192, 192, 192, 176, 160, 144, 128,
    224, 224, 224, 224, 224, 200, 176, 152, 128,
    255, 255, 255, 255, 255, 224, 192, 160, 128
  };

  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [15:0] left_reload;
    logic [15:0] right_reload;
    logic pivot_turn;
  } tracks_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tmb_cmd_if cmd_if();
  tmb_res_if res_if();
  tmb_cfg_if cfg_if();

  track_mixer_bilinear_table_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .cfg(cfg_if),
    .res(res_if)
  );

  always #5 clk = ~clk;

  int unsigned base_reg = 18204;
  int unsigned step_reg = 40;
  tracks_t pending_tracks[$];
  int fail_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_ctr = 0;
  int stall_mode = 0;

  function automatic int unsigned lerp8(input int unsigned a, input int unsigned b,
                                        input int unsigned f);
    if (b > a) begin
      return (((b - a) * f) + (a << 8)) & 32'hffff;
    end
    return ((a << 8) - ((a - b) * f)) & 32'hffff;
  endfunction

  function automatic int unsigned cell_blend(input int unsigned c0, input int unsigned c1,
                                             input int unsigned c2, input int unsigned c3,
                                             input int unsigned fy, input int unsigned fx);
    int unsigned e02, e13, diff, hi, lo, ans;
    e02 = lerp8(c0, c2, fy);
    e13 = lerp8(c1, c3, fy);
    diff = (e13 < e02) ? e02 - e13 : e13 - e02;
    hi = (fx * (diff >> 8)) & 32'hffff;
    lo = ((fx * (diff & 32'hff)) >> 8) & 32'hff;
    if (e13 < e02) begin
      ans = (e13 + hi + lo) & 32'hffff;
    end else begin
      ans = (e13 - hi - lo) & 32'hffff;
    end
    if (ans & 32'h80) begin
      return ((ans >> 8) + 1) & 32'hff;
    end
    return ans >> 8;
  endfunction

  function automatic tracks_t mix_tracks(input logic [7:0] thr, input logic [7:0] str);
    int unsigned y, x, w, i0, i1, i2, i3, lft, rgt;
    tracks_t t;
    y = (thr == 8'hff) ? 32'h800 : {21'd0, thr, 3'd0};
    x = (str == 8'hff) ? 32'h800 : {21'd0, str, 3'd0};
    w = ((y >> 8) * 9 + 8 - (x >> 8)) & 32'hff;
    i1 = w;
    i3 = w;
    if (x < 32'h800) begin
      w = (w - 1) & 32'hff;
    end
    i0 = w;
    i2 = w;
    if (y < 32'h800) begin
      i2 = i0 + 9;
      i3 = i1 + 9;
    end
    i0 = (i0 > 80) ? 80 : i0;
    i1 = (i1 > 80) ? 80 : i1;
    i2 = (i2 > 80) ? 80 : i2;
    i3 = (i3 > 80) ? 80 : i3;
    lft = cell_blend(LeftTrack[i0], LeftTrack[i1], LeftTrack[i2], LeftTrack[i3],
                     y & 32'hff, x & 32'hff);
    rgt = cell_blend(RightTrack[i0], RightTrack[i1], RightTrack[i2], RightTrack[i3],
                     y & 32'hff, x & 32'hff);
    t.pivot_turn = 1'b0;
    if (y == 32'h400) begin
      if (x > 32'h400) begin
        lft = (128 + (x - 32'h400) / 24) & 32'hff;
      end else begin
        lft = (128 - (32'h400 - x) / 24) & 32'hff;
      end
      rgt = (256 - lft) & 32'hff;
      t.pivot_turn = 1'b1;
    end
    t.left_speed = lft[7:0];
    t.right_speed = rgt[7:0];
    t.left_reload = 16'((base_reg - step_reg * lft) & 32'hffff);
    t.right_reload = 16'((base_reg - step_reg * rgt) & 32'hffff);
    return t;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    fail_count++;
  endtask

  // one item per call; the sender runs in bursts with random gaps
  task automatic send_sample(input logic [7:0] thr, input logic [7:0] str);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_if.valid <= 1'b1;
    cmd_if.throttle <= thr;
    cmd_if.steer <= str;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    pending_tracks.push_back(mix_tracks(thr, str));
    burst_left--;
  endtask

  task automatic drain;
    cmd_if.valid <= 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [tmb_pkg::CfgIdxW-1:0] idx,
                         input logic [tmb_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == tmb_pkg::RegPulseBase) begin
      base_reg = val;
    end else if (idx == tmb_pkg::RegPulseStep) begin
      step_reg = val[7:0];
    end
  endtask

  task automatic set_config(input logic [15:0] base_val, input logic [15:0] step_val,
                            input bit spare);
    cfg_put(tmb_pkg::RegPulseBase, base_val);
    cfg_put(tmb_pkg::RegPulseStep, step_val);
    if (spare) begin
      cfg_put(RegSpareA, 16'($urandom));
      cfg_put(RegSpareB, 16'($urandom));
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 9) == 0) begin
      return corner[$urandom_range(0, 6)];
    end
    return 8'($urandom);
  endfunction

  task automatic test_reset_values;
    send_sample(8'd128, 8'd128);
    send_sample(8'd255, 8'd255);
    send_sample(8'd0, 8'd0);
    send_sample(8'd200, 8'd60);
    drain();
  endtask

  task automatic test_corners;
    send_sample(8'd0, 8'd255);
    send_sample(8'd255, 8'd0);
    send_sample(8'd128, 8'd0);
    send_sample(8'd128, 8'd255);
    send_sample(8'd128, 8'd127);
    send_sample(8'd128, 8'd129);
    send_sample(8'd127, 8'd128);
    send_sample(8'd129, 8'd128);
    send_sample(8'd1, 8'd254);
    send_sample(8'd254, 8'd1);
    send_sample(8'd32, 8'd224);
    send_sample(8'd255, 8'd128);
    drain();
  endtask

  // reload wrap at both ends of the register ranges, with junk above the step width
  task automatic test_config_extremes;
    set_config(16'd0, 16'hff | 16'($urandom_range(1, 255) << 8), 1'b0);
    send_sample(8'd255, 8'd255);
    send_sample(8'd0, 8'd0);
    send_sample(8'd128, 8'd40);
    drain();
    set_config(16'hffff, 16'hff00, 1'b1);
    send_sample(8'd255, 8'd0);
    send_sample(8'd128, 8'd128);
    send_sample(8'd64, 8'd192);
    drain();
  endtask

  task automatic test_random;
    logic [7:0] thr;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          set_config(16'($urandom), 16'($urandom_range(0, 255)), 1'b0);
        end
        1: begin
          set_config(16'hffff, 16'd255, 1'b1);
        end
        2: begin
          set_config(16'd0, 16'd0, 1'b0);
        end
        default: begin
          set_config(16'($urandom), 16'($urandom), 1'b1);
        end
      endcase
      for (int n = 0; n < RandomItems / RandomPhases; n++) begin
        thr = ($urandom_range(0, 6) == 0) ? 8'd128 : pick_byte();
        send_sample(thr, pick_byte());
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    stall_ctr++;
    if (stall_ctr % 128 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= 1'($urandom);
      2: res_if.ready <= ($urandom_range(0, 3) == 0);
      default: res_if.ready <= ((stall_ctr % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    tracks_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_tracks.size() == 0) begin
        $display("unexpected result at %0t", $time);
        fail_count++;
      end else begin
        want = pending_tracks.pop_front();
        if (res_if.left_speed !== want.left_speed)
          report_mismatch("left_speed", res_if.left_speed, want.left_speed);
        if (res_if.right_speed !== want.right_speed)
          report_mismatch("right_speed", res_if.right_speed, want.right_speed);
        if (res_if.left_reload !== want.left_reload)
          report_mismatch("left_reload", res_if.left_reload, want.left_reload);
        if (res_if.right_reload !== want.right_reload)
          report_mismatch("right_reload", res_if.right_reload, want.right_reload);
        if (res_if.pivot_turn !== want.pivot_turn)
          report_mismatch("pivot_turn", res_if.pivot_turn, want.pivot_turn);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("track_mixer_bilinear_table_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.throttle = 8'd0;
    cmd_if.steer = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.index = tmb_pkg::RegPulseBase;
    cfg_if.data = 16'd0;
    res_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_corners();
    test_config_extremes();
    test_random();
    if (fail_count == 0) begin
      $display("track_mixer_bilinear_table_core_tb OK");
    end else begin
      $display("track_mixer_bilinear_table_core_tb NOT OK");
    end
    $finish;
  end

endmodule
